/* rtl/core/lcsd_pkg.sv */
// Shared widths, codes and helpers for the linear code syndrome decoder.
package lcsd_pkg;

  // Fixed field widths
  localparam int unsigned CodewordW = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned SyndW     = 8;
  localparam int unsigned MatrixW   = 64;
  localparam int unsigned RowStride = 8;
  localparam int unsigned LenW      = 4;
  localparam int unsigned CfgIdxW   = 2;

  // Default code size limits
  localparam int unsigned MaxDataBits   = 8;
  localparam int unsigned MaxParityBits = 8;

  // Register reset values
  localparam logic [LenW-1:0] DataLenRst   = 4'd4;
  localparam logic [LenW-1:0] ParityLenRst = 4'd3;

  typedef enum logic [1:0] {
    StClean  = 2'd0,
    StSingle = 2'd1,
    StDouble = 2'd2,
    StUncorr = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgParityMatrix = 2'd0,
    CfgDataLen      = 2'd1,
    CfgParityLen    = 2'd2
  } cfg_idx_e;

  // Clamp a length register into 1..hi
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v,
                                                input logic [LenW-1:0] hi);
    logic [LenW-1:0] res;
    res = v;
    if (v == '0) begin
      res = {{(LenW-1){1'b0}}, 1'b1};
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

/* rtl/core/lcsd_syndrome.sv */
// Stage one: mask the received word and fold its check columns into the syndrome.
module lcsd_syndrome import lcsd_pkg::*; #(
  parameter int unsigned N = MaxDataBits + MaxParityBits,
  parameter int unsigned R = MaxParityBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CodewordW-1:0]    codeword_i,
  input  logic [N-1:0]            pos_mask_i,
  input  logic [N-1:0][R-1:0]     cols_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [N-1:0]            word_o,
  output logic [R-1:0]            syn_o
);

  logic         valid_q;
  logic [N-1:0] word_d, word_q;
  logic [R-1:0] syn_d, syn_q;
  logic         load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Drop bits above the word and XOR the columns of set positions
  always_comb begin
    word_d = codeword_i[N-1:0] & pos_mask_i;
    syn_d  = '0;
    for (int s = 0; s < N; s++) begin
      if (word_d[s]) begin
        syn_d = syn_d ^ cols_i[s];
      end
    end
  end

  // Advance the stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Hold the payload until the next request is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      syn_q  <= syn_d;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;
  assign syn_o       = syn_q;

endmodule

/* rtl/core/lcsd_match.sv */
// Stage two: compare the syndrome against every single column and every column pair.
module lcsd_match import lcsd_pkg::*; #(
  parameter int unsigned N = MaxDataBits + MaxParityBits,
  parameter int unsigned R = MaxParityBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [N-1:0]            word_i,
  input  logic [R-1:0]            syn_i,
  input  logic [N-1:0]            pos_mask_i,
  input  logic [N-1:0][R-1:0]     cols_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [N-1:0]            word_o,
  output logic [R-1:0]            syn_o,
  output logic [N-1:0]            single_o,
  output logic [N-1:0][N-1:0]     pair_o
);

  logic                valid_q;
  logic [N-1:0]        word_q;
  logic [R-1:0]        syn_q;
  logic [N-1:0]        single_d, single_q;
  logic [N-1:0][N-1:0] pair_d, pair_q;
  logic                syn_nz;
  logic                load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign syn_nz     = |syn_i;

  // Flag matching positions; pair row q holds partners w above q
  always_comb begin
    single_d = '0;
    pair_d   = '0;
    for (int s = 0; s < N; s++) begin
      single_d[s] = syn_nz && pos_mask_i[s] && (cols_i[s] == syn_i);
    end
    for (int q = 0; q < N; q++) begin
      for (int w = 0; w < N; w++) begin
        if (w > q) begin
          pair_d[q][w] = syn_nz && pos_mask_i[w] &&
                         ((cols_i[q] ^ cols_i[w]) == syn_i);
        end
      end
    end
  end

  // Advance the stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Hold the payload until the next request is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q   <= word_i;
      syn_q    <= syn_i;
      single_q <= single_d;
      pair_q   <= pair_d;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;
  assign syn_o       = syn_q;
  assign single_o    = single_q;
  assign pair_o      = pair_q;

endmodule

/* rtl/core/lcsd_pick.sv */
// Stage three: keep the lowest single hit and the lowest partner in each pair row.
module lcsd_pick import lcsd_pkg::*; #(
  parameter int unsigned N = MaxDataBits + MaxParityBits,
  parameter int unsigned R = MaxParityBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [N-1:0]            word_i,
  input  logic [R-1:0]            syn_i,
  input  logic [N-1:0]            single_i,
  input  logic [N-1:0][N-1:0]     pair_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [N-1:0]            word_o,
  output logic [R-1:0]            syn_o,
  output logic                    has_single_o,
  output logic [N-1:0]            single_oh_o,
  output logic [N-1:0]            row_any_o,
  output logic [N-1:0][N-1:0]     row_oh_o
);

  logic                valid_q;
  logic [N-1:0]        word_q;
  logic [R-1:0]        syn_q;
  logic                has_single_q;
  logic [N-1:0]        single_oh_d, single_oh_q;
  logic [N-1:0]        row_any_d, row_any_q;
  logic [N-1:0][N-1:0] row_oh_d, row_oh_q;
  logic                load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Isolate the lowest set bit of each hit vector
  always_comb begin
    single_oh_d = single_i & (~single_i + {{(N-1){1'b0}}, 1'b1});
    for (int q = 0; q < N; q++) begin
      row_oh_d[q]  = pair_i[q] & (~pair_i[q] + {{(N-1){1'b0}}, 1'b1});
      row_any_d[q] = |pair_i[q];
    end
  end

  // Advance the stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Hold the payload until the next request is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q       <= word_i;
      syn_q        <= syn_i;
      has_single_q <= |single_i;
      single_oh_q  <= single_oh_d;
      row_any_q    <= row_any_d;
      row_oh_q     <= row_oh_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign word_o       = word_q;
  assign syn_o        = syn_q;
  assign has_single_o = has_single_q;
  assign single_oh_o  = single_oh_q;
  assign row_any_o    = row_any_q;
  assign row_oh_o     = row_oh_q;

endmodule

/* rtl/core/lcsd_fix.sv */
// Stage four: choose the flip, apply it and register the result fields.
module lcsd_fix import lcsd_pkg::*; #(
  parameter int unsigned K = MaxDataBits,
  parameter int unsigned R = MaxParityBits,
  parameter int unsigned N = K + R
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [N-1:0]            word_i,
  input  logic [R-1:0]            syn_i,
  input  logic                    has_single_i,
  input  logic [N-1:0]            single_oh_i,
  input  logic [N-1:0]            row_any_i,
  input  logic [N-1:0][N-1:0]     row_oh_i,
  input  logic [K-1:0]            kmask_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CodewordW-1:0]    corrected_word_o,
  output logic [DataW-1:0]        data_bits_o,
  output logic [SyndW-1:0]        syndrome_value_o,
  output logic [1:0]              error_status_o
);

  logic         valid_q;
  logic [N-1:0] q_oh;
  logic [N-1:0] pair_flip;
  logic [N-1:0] flip;
  logic [N-1:0] fixed;
  status_e      status_d, status_q;
  logic [N-1:0] word_q;
  logic [K-1:0] data_q;
  logic [R-1:0] syn_q;
  logic         load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Lowest pair row wins; merge its row position with its partner
  always_comb begin
    q_oh      = row_any_i & (~row_any_i + {{(N-1){1'b0}}, 1'b1});
    pair_flip = q_oh;
    for (int q = 0; q < N; q++) begin
      if (q_oh[q]) begin
        pair_flip = pair_flip | row_oh_i[q];
      end
    end
  end

  // Single flip beats pair flip; otherwise pass the word on
  always_comb begin
    flip     = '0;
    status_d = StUncorr;
    if (syn_i == '0) begin
      status_d = StClean;
    end else if (has_single_i) begin
      flip     = single_oh_i;
      status_d = StSingle;
    end else if (|row_any_i) begin
      flip     = pair_flip;
      status_d = StDouble;
    end
    fixed = word_i ^ flip;
  end

  // Advance the output valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q   <= fixed;
      data_q   <= fixed[K-1:0] & kmask_i;
      syn_q    <= syn_i;
      status_q <= status_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign corrected_word_o = CodewordW'(word_q);
  assign data_bits_o      = DataW'(data_q);
  assign syndrome_value_o = SyndW'(syn_q);
  assign error_status_o   = status_q;

endmodule

/* rtl/core/linear_code_syndrome_decoder_core.sv */
// Top level of the systematic linear block code syndrome decoder.
// Takes one codeword per cycle and returns one result per codeword, in order,
// after it passes a syndrome stage, a column and pair compare stage, a
// lowest-hit pick stage and a flip stage whose register is the output. A
// stall on the output backs up through the stage valid bits, so
// new requests keep flowing until every stage is full. Check columns come
// straight from the configuration registers, which must only be written
// while no codeword is in flight; the configuration port never stalls.
module linear_code_syndrome_decoder_core import lcsd_pkg::*; #(
  parameter int unsigned MAX_DATA_BITS   = MaxDataBits,
  parameter int unsigned MAX_PARITY_BITS = MaxParityBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [MatrixW-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CodewordW-1:0]  codeword_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CodewordW-1:0]  corrected_word_o,
  output logic [DataW-1:0]      data_bits_o,
  output logic [SyndW-1:0]      syndrome_value_o,
  output logic [1:0]            error_status_o
);

  localparam int unsigned K  = MAX_DATA_BITS;
  localparam int unsigned R  = MAX_PARITY_BITS;
  localparam int unsigned N  = K + R;
  localparam int unsigned NW = $clog2(N + 1);

  logic [MatrixW-1:0]  parity_matrix_q;
  logic [LenW-1:0]     data_len_q;
  logic [LenW-1:0]     parity_len_q;
  logic [LenW-1:0]     k_len, r_len;
  logic [NW-1:0]       n_len;
  logic [N-1:0]        pos_mask;
  logic [K-1:0]        kmask;
  logic [N-1:0][R-1:0] cols;

  logic                s1_valid, s1_ready;
  logic [N-1:0]        s1_word;
  logic [R-1:0]        s1_syn;
  logic                s2_valid, s2_ready;
  logic [N-1:0]        s2_word;
  logic [R-1:0]        s2_syn;
  logic [N-1:0]        s2_single;
  logic [N-1:0][N-1:0] s2_pair;
  logic                s3_valid, s3_ready;
  logic [N-1:0]        s3_word;
  logic [R-1:0]        s3_syn;
  logic                s3_has_single;
  logic [N-1:0]        s3_single_oh;
  logic [N-1:0]        s3_row_any;
  logic [N-1:0][N-1:0] s3_row_oh;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_matrix_q <= '0;
      data_len_q      <= DataLenRst;
      parity_len_q    <= ParityLenRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgParityMatrix: parity_matrix_q <= cfg_data_i;
        CfgDataLen:      data_len_q      <= cfg_data_i[LenW-1:0];
        CfgParityLen:    parity_len_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective code size and position masks
  always_comb begin
    k_len = clamp_len(data_len_q, LenW'(K));
    r_len = clamp_len(parity_len_q, LenW'(R));
    n_len = NW'(k_len) + NW'(r_len);
    for (int s = 0; s < N; s++) begin
      pos_mask[s] = NW'(s) < n_len;
    end
    for (int i = 0; i < K; i++) begin
      kmask[i] = LenW'(i) < k_len;
    end
  end

  // Build check columns: matrix rows for data, unit vectors for parity
  always_comb begin
    cols = '0;
    for (int s = 0; s < N; s++) begin
      if (NW'(s) >= NW'(k_len)) begin
        for (int t = 0; t < R; t++) begin
          cols[s][t] = (NW'(s) - NW'(k_len)) == NW'(t);
        end
      end else if (s < K) begin
        for (int t = 0; t < R; t++) begin
          cols[s][t] = (LenW'(t) < r_len) && parity_matrix_q[s*RowStride + t];
        end
      end
    end
  end

  lcsd_syndrome #(.N(N), .R(R)) u_syndrome (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .codeword_i  (codeword_i),
    .pos_mask_i  (pos_mask),
    .cols_i      (cols),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .word_o      (s1_word),
    .syn_o       (s1_syn)
  );

  lcsd_match #(.N(N), .R(R)) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .word_i      (s1_word),
    .syn_i       (s1_syn),
    .pos_mask_i  (pos_mask),
    .cols_i      (cols),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .word_o      (s2_word),
    .syn_o       (s2_syn),
    .single_o    (s2_single),
    .pair_o      (s2_pair)
  );

  lcsd_pick #(.N(N), .R(R)) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s2_valid),
    .in_ready_o   (s2_ready),
    .word_i       (s2_word),
    .syn_i        (s2_syn),
    .single_i     (s2_single),
    .pair_i       (s2_pair),
    .out_valid_o  (s3_valid),
    .out_ready_i  (s3_ready),
    .word_o       (s3_word),
    .syn_o        (s3_syn),
    .has_single_o (s3_has_single),
    .single_oh_o  (s3_single_oh),
    .row_any_o    (s3_row_any),
    .row_oh_o     (s3_row_oh)
  );

  lcsd_fix #(.K(K), .R(R), .N(N)) u_fix (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s3_valid),
    .in_ready_o       (s3_ready),
    .word_i           (s3_word),
    .syn_i            (s3_syn),
    .has_single_i     (s3_has_single),
    .single_oh_i      (s3_single_oh),
    .row_any_i        (s3_row_any),
    .row_oh_i         (s3_row_oh),
    .kmask_i          (kmask),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .corrected_word_o (corrected_word_o),
    .data_bits_o      (data_bits_o),
    .syndrome_value_o (syndrome_value_o),
    .error_status_o   (error_status_o)
  );

  // A clean status always carries a zero syndrome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_status_o == StClean) |-> (syndrome_value_o == '0))
    else $error("clean status with nonzero syndrome");

  // Any nonclean status needs a nonzero syndrome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_status_o != StClean) |-> (syndrome_value_o != '0))
    else $error("correction reported with zero syndrome");

  // Input backpressure only comes from a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output is free");

endmodule
